// ----- rtl/core/rmf_pkg.sv -----
`timescale 1ns / 1ps

package rmf_pkg;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SORT,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic load;
      logic sort;
      logic phase;
   } cell_ctrl_type;

endpackage

// ----- rtl/core/rmf_cell.sv -----
`timescale 1ns / 1ps

module rmf_cell #(
   parameter int WINDOW      = 8,
   parameter int SAMPLE_BITS = 16,
   parameter int AGE_BITS    = 3,
   parameter int IDX         = 0
) (
   input  logic                          clock,
   input  logic                          reset,
   input  rmf_pkg::cell_ctrl_type        ctrl,
   input  logic signed [SAMPLE_BITS-1:0] sample,
   input  logic signed [SAMPLE_BITS-1:0] lo_value,
   input  logic        [AGE_BITS-1:0]    lo_age,
   input  logic signed [SAMPLE_BITS-1:0] hi_value,
   input  logic        [AGE_BITS-1:0]    hi_age,
   output logic signed [SAMPLE_BITS-1:0] value,
   output logic        [AGE_BITS-1:0]    age,
   output logic                          oldest
);

   localparam logic              PARITY   = 1'(IDX % 2);
   localparam logic              HAS_HI   = (IDX + 1 < WINDOW);
   localparam logic              HAS_LO   = (IDX > 0);
   localparam logic [AGE_BITS-1:0] AGE_MAX = AGE_BITS'(WINDOW - 1);
   localparam logic [AGE_BITS-1:0] AGE_RST = AGE_BITS'(IDX);

   logic signed [SAMPLE_BITS-1:0] value_ff, value_in;
   logic        [AGE_BITS-1:0]    age_ff, age_in;
   logic                          is_lower, is_upper;

   assign is_lower = HAS_HI && (ctrl.phase == PARITY);
   assign is_upper = HAS_LO && (ctrl.phase != PARITY);
   assign oldest   = (age_ff == AGE_MAX);

   always_comb begin
      value_in = value_ff;
      age_in   = age_ff;
      if (ctrl.load) begin
         if (oldest) begin
            value_in = sample;
            age_in   = '0;
         end else begin
            age_in = age_ff + AGE_BITS'(1);
         end
      end else if (ctrl.sort) begin
         if (is_lower && (value_ff > hi_value)) begin
            value_in = hi_value;
            age_in   = hi_age;
         end else if (is_upper && (lo_value > value_ff)) begin
            value_in = lo_value;
            age_in   = lo_age;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff <= '0;
         age_ff   <= AGE_RST;
      end else begin
         value_ff <= value_in;
         age_ff   <= age_in;
      end
   end

   assign value = value_ff;
   assign age   = age_ff;

endmodule

// ----- rtl/core/running_median_filter_top.sv -----
`timescale 1ns / 1ps

// Running median over the last WINDOW steering samples.
// A request on req_ carries one signed sample; the block answers each request
// with exactly one response on rsp_ carrying the median of the window after
// the new sample is inserted (the upper median for an even window).
// The window is held in a row of cells kept in ascending order. Each cell
// also keeps the age of its sample, so a new sample replaces the oldest one
// in place, and WINDOW odd-even transposition passes restore the order.
// A request is taken only while the block is idle. Once a request is
// accepted, the block runs the odd-even sort passes over the cell row and
// then presents the response; it takes no new request until that response
// has been taken, so only one sample is in the block at a time.
// While rsp_stall is high the response is held stable and no new request
// is accepted. Reset clears the window to zero, so the first medians count
// those zeros as samples, and leaves the block idle.

module running_median_filter_top #(
   parameter int WINDOW      = 8,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [SAMPLE_BITS-1:0] req_steer_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [SAMPLE_BITS-1:0] rsp_median_steer
);

   localparam int AGE_BITS = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int CNT_BITS = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(WINDOW - 1);

   rmf_pkg::state_type     state_ff, state_in;
   logic [CNT_BITS-1:0]    cnt_ff, cnt_in;
   rmf_pkg::cell_ctrl_type ctrl;
   logic                   req_accept;

   logic signed [SAMPLE_BITS-1:0] cell_value [WINDOW];
   logic        [AGE_BITS-1:0]    cell_age [WINDOW];
   logic        [WINDOW-1:0]      cell_oldest;

   assign req_accept = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         rmf_pkg::ST_IDLE: begin
            if (req_accept) begin
               state_in = rmf_pkg::ST_SORT;
               cnt_in   = '0;
            end
         end
         rmf_pkg::ST_SORT: begin
            if (cnt_ff == CNT_LAST) begin
               state_in = rmf_pkg::ST_OUT;
            end else begin
               cnt_in = cnt_ff + CNT_BITS'(1);
            end
         end
         rmf_pkg::ST_OUT: begin
            if (!rsp_stall) begin
               state_in = rmf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rmf_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_stall  = 1'b1;
      rsp_valid  = 1'b0;
      ctrl.load  = 1'b0;
      ctrl.sort  = 1'b0;
      ctrl.phase = cnt_ff[0];
      unique case (state_ff)
         rmf_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            ctrl.load = req_valid;
         end
         rmf_pkg::ST_SORT: begin
            ctrl.sort = 1'b1;
         end
         rmf_pkg::ST_OUT: begin
            rsp_valid = 1'b1;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rmf_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   for (genvar i = 0; i < WINDOW; i++) begin : g_cell
      logic signed [SAMPLE_BITS-1:0] lo_value, hi_value;
      logic        [AGE_BITS-1:0]    lo_age, hi_age;

      if (i > 0) begin : g_lo
         assign lo_value = cell_value[i-1];
         assign lo_age   = cell_age[i-1];
      end else begin : g_lo_edge
         assign lo_value = cell_value[i];
         assign lo_age   = cell_age[i];
      end

      if (i + 1 < WINDOW) begin : g_hi
         assign hi_value = cell_value[i+1];
         assign hi_age   = cell_age[i+1];
      end else begin : g_hi_edge
         assign hi_value = cell_value[i];
         assign hi_age   = cell_age[i];
      end

      rmf_cell #(
         .WINDOW      (WINDOW),
         .SAMPLE_BITS (SAMPLE_BITS),
         .AGE_BITS    (AGE_BITS),
         .IDX         (i)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (ctrl),
         .sample   (req_steer_sample),
         .lo_value (lo_value),
         .lo_age   (lo_age),
         .hi_value (hi_value),
         .hi_age   (hi_age),
         .value    (cell_value[i]),
         .age      (cell_age[i]),
         .oldest   (cell_oldest[i])
      );
   end

   assign rsp_median_steer = cell_value[WINDOW / 2];

   a_one_oldest: assert property (@(posedge clock) disable iff (reset)
      $onehot(cell_oldest))
      else $error("window must hold exactly one oldest sample");

   a_accept_starts_sort: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == rmf_pkg::ST_SORT) && !rsp_valid)
      else $error("accepted request did not start the sort passes");

   a_busy_while_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request accepted while a response is pending");

   a_sort_window_stable: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rmf_pkg::ST_OUT) && $past(state_ff == rmf_pkg::ST_OUT)
      |-> $stable(rsp_median_steer))
      else $error("cell row changed while the response was held");

endmodule

// ----- test/tb_running_median_filter_top.sv -----
`timescale 1ns / 1ps

module tb_running_median_filter_top;

   localparam int WINDOW      = 8;
   localparam int SAMPLE_BITS = 16;
   localparam int RANDOM_ITEMS = 750;
   localparam int DIRECTED_ROWS = 22;
   localparam int IDLE_LIMIT = 5000;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam logic signed [SAMPLE_BITS-1:0] MAX_SAMPLE = 16'sh7FFF;
   localparam logic signed [SAMPLE_BITS-1:0] MIN_SAMPLE = 16'sh8000;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                          known;
      logic signed [SAMPLE_BITS-1:0] median;
   } steer_row_type;

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   logic signed [SAMPLE_BITS-1:0] req_steer_sample;
   logic                          rsp_valid;
   logic                          rsp_stall;
   logic signed [SAMPLE_BITS-1:0] rsp_median_steer;

   steer_row_type                 steer_rows [DIRECTED_ROWS];
   logic signed [SAMPLE_BITS-1:0] window_copy [WINDOW];
   int                            window_ptr;
   logic signed [SAMPLE_BITS-1:0] pending_medians [$];
   int                            error_count;
   int                            idle_cycles;
   bit                            long_hold_pending;

   running_median_filter_top #(
      .WINDOW      (WINDOW),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_steer_sample (req_steer_sample),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_median_steer (rsp_median_steer)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string msg);
      $display("%0t mismatch: %s", $realtime, msg);
      error_count++;
   endtask

   function automatic logic signed [SAMPLE_BITS-1:0] insert_and_median(
      input logic signed [SAMPLE_BITS-1:0] sample
   );
      logic signed [SAMPLE_BITS-1:0] ordered [WINDOW];
      logic signed [SAMPLE_BITS-1:0] key;
      int i;
      int j;
      window_copy[window_ptr] = sample;
      window_ptr = (window_ptr + 1) % WINDOW;
      for (i = 0; i < WINDOW; i++) begin
         key = window_copy[i];
         j = i;
         while (j > 0 && ordered[j-1] > key) begin
            ordered[j] = ordered[j-1];
            j--;
         end
         ordered[j] = key;
      end
      return ordered[WINDOW/2];
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) begin
         return 0;
      end else if (r < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 60);
   endfunction

   function automatic logic signed [SAMPLE_BITS-1:0] pick_sample(
      input logic signed [SAMPLE_BITS-1:0] last
   );
      int r;
      r = $urandom_range(0, 9);
      case (r)
         0, 1, 2, 3: begin
            return SAMPLE_BITS'($urandom);
         end
         4, 5: begin
            return SAMPLE_BITS'($signed($urandom_range(0, 15)) - 8);
         end
         6: begin
            case ($urandom_range(0, 4))
               0: return MAX_SAMPLE;
               1: return MIN_SAMPLE;
               2: return -16'sd1;
               3: return 16'sd1;
               default: return 16'sd0;
            endcase
         end
         7, 8: begin
            return last;
         end
         default: begin
            if ($urandom_range(0, 1) == 1) begin
               return MAX_SAMPLE - SAMPLE_BITS'($urandom_range(0, 7));
            end
            return MIN_SAMPLE + SAMPLE_BITS'($urandom_range(0, 7));
         end
      endcase
   endfunction

   task automatic send_sample(
      input logic signed [SAMPLE_BITS-1:0] sample,
      input logic                          known,
      input logic signed [SAMPLE_BITS-1:0] known_median,
      input int                            gap
   );
      logic signed [SAMPLE_BITS-1:0] predicted;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_steer_sample <= sample;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = insert_and_median(sample);
      pending_medians = {pending_medians, (known ? known_median : predicted)};
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_medians.size() == 0) begin
            report_mismatch($sformatf("unexpected response median_steer=%0d",
                                      rsp_median_steer));
         end else begin
            if (rsp_median_steer !== pending_medians[0]) begin
               report_mismatch($sformatf("median_steer got %0d, want %0d",
                                         rsp_median_steer, pending_medians[0]));
            end
            void'(pending_medians.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t no handshake for %0d cycles", $realtime, IDLE_LIMIT);
         $display("tb_running_median_filter_top: FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int hold_left;
      int stall_left;
      int free_left;
      logic next_stall;
      hold_left  = 0;
      stall_left = 0;
      free_left  = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_pending) begin
            long_hold_pending = 1'b0;
            hold_left = LONG_HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            next_stall = 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            next_stall = 1'b1;
         end else if (free_left > 0) begin
            free_left--;
            next_stall = 1'b0;
         end else begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4: stall_left = 0;
               5, 6, 7, 8: stall_left = $urandom_range(1, 3);
               default: stall_left = $urandom_range(10, 50);
            endcase
            if ($urandom_range(0, 99) < 85) begin
               free_left = $urandom_range(1, 6);
            end else begin
               free_left = $urandom_range(40, 120);
            end
            next_stall = 1'b0;
         end
         rsp_stall <= next_stall;
      end
   end

   initial begin
      logic signed [SAMPLE_BITS-1:0] last_sample;
      int i;
      int gap;
      error_count       = 0;
      idle_cycles       = 0;
      long_hold_pending = 1'b0;
      window_ptr        = 0;
      for (i = 0; i < WINDOW; i++) begin
         window_copy[i] = '0;
      end

      steer_rows[0]  = '{MAX_SAMPLE,   1'b1, 16'sd0};
      steer_rows[1]  = '{MIN_SAMPLE,   1'b1, 16'sd0};
      steer_rows[2]  = '{MAX_SAMPLE,   1'b1, 16'sd0};
      steer_rows[3]  = '{MAX_SAMPLE,   1'b1, 16'sd0};
      steer_rows[4]  = '{MAX_SAMPLE,   1'b1, MAX_SAMPLE};
      steer_rows[5]  = '{-16'sd1,      1'b0, 16'sd0};
      steer_rows[6]  = '{16'sd1,       1'b0, 16'sd0};
      steer_rows[7]  = '{16'sd0,       1'b0, 16'sd0};
      steer_rows[8]  = '{16'sd1234,    1'b0, 16'sd0};
      steer_rows[9]  = '{16'sd1234,    1'b0, 16'sd0};
      steer_rows[10] = '{16'sd1234,    1'b0, 16'sd0};
      steer_rows[11] = '{16'sd1234,    1'b0, 16'sd0};
      steer_rows[12] = '{16'sd1234,    1'b0, 16'sd0};
      steer_rows[13] = '{16'sd1234,    1'b0, 16'sd0};
      steer_rows[14] = '{16'sd1234,    1'b0, 16'sd0};
      steer_rows[15] = '{16'sd1234,    1'b1, 16'sd1234};
      steer_rows[16] = '{MIN_SAMPLE,   1'b0, 16'sd0};
      steer_rows[17] = '{16'sh5555,    1'b0, 16'sd0};
      steer_rows[18] = '{16'shAAAA,    1'b0, 16'sd0};
      steer_rows[19] = '{-16'sd1,      1'b0, 16'sd0};
      steer_rows[20] = '{16'sd1,       1'b0, 16'sd0};
      steer_rows[21] = '{MAX_SAMPLE,   1'b0, 16'sd0};

      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_steer_sample <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < DIRECTED_ROWS; i++) begin
         send_sample(steer_rows[i].sample, steer_rows[i].known, steer_rows[i].median,
                     pick_gap());
      end

      last_sample = '0;
      for (i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == 250) begin
            long_hold_pending = 1'b1;
         end
         if (i == 500) begin
            req_valid <= 1'b0;
            @(posedge clock);
            while (pending_medians.size() != 0) @(posedge clock);
         end
         gap = ((i % 100) < 30) ? 0 : pick_gap();
         last_sample = pick_sample(last_sample);
         send_sample(last_sample, 1'b0, '0, gap);
      end

      req_valid <= 1'b0;
      while (pending_medians.size() != 0) @(posedge clock);
      repeat (WINDOW + 10) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_running_median_filter_top: PASS");
      end else begin
         $display("tb_running_median_filter_top: FAIL");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/core/rmf_pkg.sv
rtl/core/rmf_cell.sv
rtl/core/running_median_filter_top.sv
test/tb_running_median_filter_top.sv
